@@ rtl/rc6_pkg.sv @@
package rc6_pkg;

   localparam int MaxRounds   = 125;
   localparam int MaxKeyWords = 8;
   localparam int StoreDepth  = 2 * MaxRounds + 4;
   localparam int KeyAw       = $clog2(StoreDepth);
   localparam int KwAw        = $clog2(MaxKeyWords);
   localparam int MaxKeyBits  = 32 * MaxKeyWords;

   localparam logic [31:0] RC6_P32 = 32'hB7E1_5163;
   localparam logic [31:0] RC6_Q32 = 32'h9E37_79B9;
   localparam logic [4:0]  RC6_LGW = 5'd5;

   // configuration register indexes
   localparam logic [2:0] CSR_ROUNDS  = 3'd0;
   localparam logic [2:0] CSR_KEY_LEN = 3'd1;
   localparam logic [2:0] CSR_KEY0    = 3'd2;
   localparam logic [2:0] CSR_KEY1    = 3'd3;
   localparam logic [2:0] CSR_KEY2    = 3'd4;
   localparam logic [2:0] CSR_KEY3    = 3'd5;

   typedef logic [KeyAw-1:0] key_addr_type;

   typedef struct packed {
      logic         we;
      key_addr_type addr;
      logic [31:0]  wdata;
   } ram_req_type;

   typedef struct packed {
      logic idle;
      logic done;
   } core_status_type;

   typedef enum logic [2:0] {
      KS_LOAD, KS_FILL, KS_MIX_RD, KS_MIX_A, KS_MIX_B, KS_DONE
   } ks_state_type;

   typedef enum logic [3:0] {
      CS_IDLE, CS_PRE0, CS_PRE1, CS_PRE2,
      CS_RND0, CS_RND1, CS_RND2, CS_RND3,
      CS_POST0, CS_POST1, CS_POST2, CS_FIN
   } cs_state_type;

   function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
      logic [63:0] t;
      t = {x, x} << n;
      return t[63:32];
   endfunction

   function automatic logic [31:0] rotr32(input logic [31:0] x, input logic [4:0] n);
      logic [63:0] t;
      t = {x, x} >> n;
      return t[31:0];
   endfunction

   // x * (2x + 1) mod 2^32, then rotate by lg w
   function automatic logic [31:0] quad_mix(input logic [31:0] x);
      logic [31:0] y;
      logic [31:0] m;
      y = {x[30:0], 1'b1};
      m = x * y;
      return rotl32(m, RC6_LGW);
   endfunction

endpackage

@@ rtl/rc6_ram.sv @@
module rc6_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 254
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/rc6_key_sched.sv @@
module rc6_key_sched (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    restart,
   input  logic [6:0]              rounds_eff,
   input  logic [8:0]              key_len,
   input  logic [3:0][63:0]        key_material,
   input  logic [31:0]             ram_rdata,
   output rc6_pkg::ram_req_type    ram_req,
   output logic                    done
);

   import rc6_pkg::*;

   ks_state_type state_ff, state_in;
   key_addr_type cnt_ff, cnt_in;
   key_addr_type ia_ff, ia_in;
   logic [KwAw-1:0] ib_ff, ib_in;
   logic [9:0]  step_ff, step_in;
   logic [31:0] val_ff, val_in;
   logic [31:0] ka_ff, ka_in;
   logic [31:0] kb_ff, kb_in;
   logic [31:0] lw_ff [MaxKeyWords];
   logic        lw_we;
   logic [31:0] lw_wdata;
   logic [31:0] loaded [MaxKeyWords];

   key_addr_type nkeys;
   logic [8:0]  bits;
   logic [9:0]  bits_sum;
   logic [3:0]  nwords;
   logic [5:0]  nbytes;
   key_addr_type maxw;
   logic [9:0]  steps;
   logic [31:0] sum_a;
   logic [31:0] sum_b;
   logic [31:0] kab;

   // derive schedule sizes from the configuration
   always_comb begin
      nkeys    = {rounds_eff, 1'b0} + 8'd4;
      bits     = (key_len > 9'(MaxKeyBits)) ? 9'(MaxKeyBits) : key_len;
      bits_sum = {1'b0, bits} + 10'd31;
      nwords   = (bits_sum[9:5] == 5'd0) ? 4'd1 : bits_sum[8:5];
      nbytes   = bits[8:3];
      maxw     = (nkeys > {4'd0, nwords}) ? nkeys : {4'd0, nwords};
      steps    = {2'b0, maxw} + {1'b0, maxw, 1'b0};
   end

   // pack whole key bytes into key words, zero beyond the key length
   always_comb begin
      for (int w = 0; w < MaxKeyWords; w++) begin
         loaded[w] = '0;
         for (int j = 0; j < 4; j++) begin
            if ((4 * w + j) < int'(nbytes)) begin
               loaded[w][8*j +: 8] = key_material[((4*w+j) >> 3) & 3][8*((4*w+j) & 7) +: 8];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         state_ff <= KS_LOAD;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff  <= cnt_in;
      ia_ff   <= ia_in;
      ib_ff   <= ib_in;
      step_ff <= step_in;
      val_ff  <= val_in;
      ka_ff   <= ka_in;
      kb_ff   <= kb_in;
      for (int w = 0; w < MaxKeyWords; w++) begin
         if (state_ff == KS_LOAD) begin
            lw_ff[w] <= loaded[w];
         end else if (lw_we && (ib_ff == KwAw'(w))) begin
            lw_ff[w] <= lw_wdata;
         end
      end
   end

   // sequence fill and mixing through the shared add and rotate path
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      ia_in    = ia_ff;
      ib_in    = ib_ff;
      step_in  = step_ff;
      val_in   = val_ff;
      ka_in    = ka_ff;
      kb_in    = kb_ff;
      lw_we    = 1'b0;
      ram_req  = '0;
      done     = 1'b0;
      kab      = ka_ff + kb_ff;
      sum_a    = ram_rdata + kab;
      sum_b    = lw_ff[ib_ff] + kab;
      lw_wdata = rotl32(sum_b, kab[4:0]);
      case (state_ff)
         KS_LOAD: begin
            cnt_in   = '0;
            ia_in    = '0;
            ib_in    = '0;
            step_in  = '0;
            val_in   = RC6_P32;
            ka_in    = '0;
            kb_in    = '0;
            state_in = KS_FILL;
         end
         KS_FILL: begin
            ram_req.we    = 1'b1;
            ram_req.addr  = cnt_ff;
            ram_req.wdata = val_ff;
            cnt_in        = cnt_ff + 8'd1;
            val_in        = val_ff + RC6_Q32;
            if (cnt_ff == nkeys - 8'd1) begin
               state_in = KS_MIX_RD;
            end
         end
         KS_MIX_RD: begin
            ram_req.addr = ia_ff;
            state_in     = KS_MIX_A;
         end
         KS_MIX_A: begin
            ka_in         = rotl32(sum_a, 5'd3);
            ram_req.we    = 1'b1;
            ram_req.addr  = ia_ff;
            ram_req.wdata = ka_in;
            state_in      = KS_MIX_B;
         end
         KS_MIX_B: begin
            lw_we   = 1'b1;
            kb_in   = lw_wdata;
            ia_in   = (ia_ff == nkeys - 8'd1) ? '0 : ia_ff + 8'd1;
            ib_in   = ({1'b0, ib_ff} == nwords - 4'd1) ? '0 : ib_ff + KwAw'(1);
            step_in = step_ff + 10'd1;
            if (step_ff == steps - 10'd1) begin
               state_in = KS_DONE;
            end else begin
               state_in = KS_MIX_RD;
            end
         end
         KS_DONE: begin
            done = 1'b1;
         end
         default: begin
            state_in = KS_LOAD;
         end
      endcase
   end

   ap_ia_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == KS_MIX_RD || state_ff == KS_MIX_A || state_ff == KS_MIX_B)
      |-> ia_ff < nkeys)
      else $error("key index beyond round key count");

   ap_ib_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == KS_MIX_RD || state_ff == KS_MIX_A || state_ff == KS_MIX_B)
      |-> {1'b0, ib_ff} < nwords)
      else $error("key word index beyond key word count");

   ap_mix_order: assert property (@(posedge clock) disable iff (reset || restart)
      (state_ff == KS_MIX_A) |=> (state_ff == KS_MIX_B))
      else $error("mixing step lost its second half");

endmodule

@@ rtl/rc6_cipher_core.sv @@
module rc6_cipher_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    mode,
   input  logic [31:0]             word_a,
   input  logic [31:0]             word_b,
   input  logic [31:0]             word_c,
   input  logic [31:0]             word_d,
   input  logic [6:0]              rounds_eff,
   input  logic [31:0]             ram_rdata,
   input  logic                    take,
   output rc6_pkg::key_addr_type   ram_addr,
   output rc6_pkg::core_status_type status,
   output logic [31:0]             out_a,
   output logic [31:0]             out_b,
   output logic [31:0]             out_c,
   output logic [31:0]             out_d
);

   import rc6_pkg::*;

   cs_state_type state_ff, state_in;
   logic        dec_ff, dec_in;
   logic [6:0]  i_ff, i_in;
   logic [31:0] a_ff, a_in, b_ff, b_in, c_ff, c_in, d_ff, d_in;
   logic [31:0] t_ff, t_in, u_ff, u_in, k0_ff, k0_in, k1_ff, k1_in;
   logic [31:0] mix_in;
   logic [31:0] mix_out;
   logic [31:0] an, cn;
   key_addr_type last_even;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
      dec_ff <= dec_in;
      i_ff   <= i_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      c_ff   <= c_in;
      d_ff   <= d_in;
      t_ff   <= t_in;
      u_ff   <= u_in;
      k0_ff  <= k0_in;
      k1_ff  <= k1_in;
   end

   // one shared quadratic mixer, registered before use
   assign mix_in  = (state_ff == CS_RND1) ? b_ff : d_ff;
   assign mix_out = quad_mix(mix_in);

   // step pre-whitening, rounds and post-whitening
   always_comb begin
      state_in  = state_ff;
      dec_in    = dec_ff;
      i_in      = i_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      c_in      = c_ff;
      d_in      = d_ff;
      t_in      = t_ff;
      u_in      = u_ff;
      k0_in     = k0_ff;
      k1_in     = k1_ff;
      ram_addr  = '0;
      last_even = {rounds_eff, 1'b0} + 8'd2;
      an        = '0;
      cn        = '0;
      status    = '0;
      case (state_ff)
         CS_IDLE: begin
            status.idle = 1'b1;
            if (start) begin
               dec_in   = mode;
               a_in     = word_a;
               b_in     = word_b;
               c_in     = word_c;
               d_in     = word_d;
               state_in = CS_PRE0;
            end
         end
         CS_PRE0: begin
            ram_addr = dec_ff ? last_even : 8'd0;
            state_in = CS_PRE1;
         end
         CS_PRE1: begin
            ram_addr = dec_ff ? last_even + 8'd1 : 8'd1;
            if (dec_ff) begin
               a_in = a_ff - ram_rdata;
            end else begin
               b_in = b_ff + ram_rdata;
            end
            state_in = CS_PRE2;
         end
         CS_PRE2: begin
            if (dec_ff) begin
               c_in = c_ff - ram_rdata;
            end else begin
               d_in = d_ff + ram_rdata;
            end
            i_in     = dec_ff ? rounds_eff : 7'd1;
            state_in = (rounds_eff == 7'd0) ? CS_POST0 : CS_RND0;
         end
         CS_RND0: begin
            ram_addr = {i_ff, 1'b0};
            // undo the word rotation ahead of a decrypt round
            if (dec_ff) begin
               a_in = d_ff;
               b_in = a_ff;
               c_in = b_ff;
               d_in = c_ff;
            end
            state_in = CS_RND1;
         end
         CS_RND1: begin
            ram_addr = {i_ff, 1'b1};
            k0_in    = ram_rdata;
            t_in     = mix_out;
            state_in = CS_RND2;
         end
         CS_RND2: begin
            k1_in    = ram_rdata;
            u_in     = mix_out;
            state_in = CS_RND3;
         end
         CS_RND3: begin
            if (dec_ff) begin
               cn   = rotr32(c_ff - k1_ff, t_ff[4:0]) ^ u_ff;
               an   = rotr32(a_ff - k0_ff, u_ff[4:0]) ^ t_ff;
               a_in = an;
               c_in = cn;
               i_in = i_ff - 7'd1;
               state_in = (i_ff == 7'd1) ? CS_POST0 : CS_RND0;
            end else begin
               an   = rotl32(a_ff ^ t_ff, u_ff[4:0]) + k0_ff;
               cn   = rotl32(c_ff ^ u_ff, t_ff[4:0]) + k1_ff;
               a_in = b_ff;
               b_in = cn;
               c_in = d_ff;
               d_in = an;
               i_in = i_ff + 7'd1;
               state_in = (i_ff == rounds_eff) ? CS_POST0 : CS_RND0;
            end
         end
         CS_POST0: begin
            ram_addr = dec_ff ? 8'd1 : last_even;
            state_in = CS_POST1;
         end
         CS_POST1: begin
            ram_addr = dec_ff ? 8'd0 : last_even + 8'd1;
            if (dec_ff) begin
               d_in = d_ff - ram_rdata;
            end else begin
               a_in = a_ff + ram_rdata;
            end
            state_in = CS_POST2;
         end
         CS_POST2: begin
            if (dec_ff) begin
               b_in = b_ff - ram_rdata;
            end else begin
               c_in = c_ff + ram_rdata;
            end
            state_in = CS_FIN;
         end
         CS_FIN: begin
            status.done = 1'b1;
            if (take) begin
               state_in = CS_IDLE;
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

   assign out_a = a_ff;
   assign out_b = b_ff;
   assign out_c = c_ff;
   assign out_d = d_ff;

endmodule

@@ rtl/rc6_block_cipher.sv @@
// RC6-32/r/b block cipher, one 128-bit block per beat, encrypt or decrypt by
// req_mode. Writing any of configuration registers 0 to 5 (round count, key
// length, four key words) starts a fresh key expansion; req_ready stays low
// until it is done. Expansion loads the key words, fills the 2r+4 round keys
// and mixes them with the key words, and it runs after reset too. A block
// is accepted only while the core is idle, so the next block waits until the
// previous result has moved to the output register; the single-port round
// key memory gives one key a cycle and one shared 32x32 multiplier forms
// both quadratic terms of a round. A finished result
// waits in the output register while the next block is accepted.
module rc6_block_cipher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic [31:0] req_word_a,
   input  logic [31:0] req_word_b,
   input  logic [31:0] req_word_c,
   input  logic [31:0] req_word_d,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_out_a,
   output logic [31:0] rsp_out_b,
   output logic [31:0] rsp_out_c,
   output logic [31:0] rsp_out_d,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   import rc6_pkg::*;

   logic [6:0]       rounds_ff;
   logic [8:0]       key_len_ff;
   logic [3:0][63:0] key_ff;
   logic [6:0]       rounds_eff;
   logic             restart;
   logic             ks_done;
   ram_req_type      ks_req;
   ram_req_type      ram_req;
   key_addr_type     core_addr;
   logic [31:0]      ram_rdata;
   core_status_type  core_status;
   logic             take;
   logic             accept;
   logic [31:0]      core_a, core_b, core_c, core_d;
   logic             rsp_valid_ff;
   logic [31:0]      out_a_ff, out_b_ff, out_c_ff, out_d_ff;

   // hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rounds_ff  <= 7'd20;
         key_len_ff <= 9'd128;
         key_ff     <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ROUNDS:  rounds_ff  <= csr_wdata[6:0];
            CSR_KEY_LEN: key_len_ff <= csr_wdata[8:0];
            CSR_KEY0:    key_ff[0]  <= csr_wdata;
            CSR_KEY1:    key_ff[1]  <= csr_wdata;
            CSR_KEY2:    key_ff[2]  <= csr_wdata;
            CSR_KEY3:    key_ff[3]  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign restart    = csr_we && (csr_index inside {[CSR_ROUNDS:CSR_KEY3]});
   assign rounds_eff = (rounds_ff > 7'(MaxRounds)) ? 7'(MaxRounds) : rounds_ff;

   rc6_key_sched u_key_sched (
      .clock        (clock),
      .reset        (reset),
      .restart      (restart),
      .rounds_eff   (rounds_eff),
      .key_len      (key_len_ff),
      .key_material (key_ff),
      .ram_rdata    (ram_rdata),
      .ram_req      (ks_req),
      .done         (ks_done)
   );

   // hand the memory port to the cipher once expansion is done
   always_comb begin
      if (ks_done) begin
         ram_req       = '0;
         ram_req.addr  = core_addr;
      end else begin
         ram_req = ks_req;
      end
   end

   rc6_ram #(
      .WIDTH (32),
      .DEPTH (StoreDepth)
   ) u_round_keys (
      .clock (clock),
      .we    (ram_req.we),
      .addr  (ram_req.addr),
      .wdata (ram_req.wdata),
      .rdata (ram_rdata)
   );

   assign req_ready = ks_done && core_status.idle;
   assign accept    = req_valid && req_ready;
   assign take      = core_status.done && (!rsp_valid_ff || rsp_ready);

   rc6_cipher_core u_core (
      .clock      (clock),
      .reset      (reset),
      .start      (accept),
      .mode       (req_mode),
      .word_a     (req_word_a),
      .word_b     (req_word_b),
      .word_c     (req_word_c),
      .word_d     (req_word_d),
      .rounds_eff (rounds_eff),
      .ram_rdata  (ram_rdata),
      .take       (take),
      .ram_addr   (core_addr),
      .status     (core_status),
      .out_a      (core_a),
      .out_b      (core_b),
      .out_c      (core_c),
      .out_d      (core_d)
   );

   // hold the result beat until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (take) begin
         out_a_ff <= core_a;
         out_b_ff <= core_b;
         out_c_ff <= core_c;
         out_d_ff <= core_d;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_a = out_a_ff;
   assign rsp_out_b = out_b_ff;
   assign rsp_out_c = out_c_ff;
   assign rsp_out_d = out_d_ff;

   ap_restart: assert property (@(posedge clock) disable iff (reset)
      restart |=> !ks_done)
      else $error("configuration write did not restart key expansion");

   ap_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("second block accepted while one is in work");

   ap_no_key_write: assert property (@(posedge clock) disable iff (reset)
      ram_req.we |-> !ks_done)
      else $error("round key write outside expansion");

endmodule

@@ dv/tb_rc6_block_cipher.sv @@
`timescale 1ns / 1ps

module tb_rc6_block_cipher;
   import rc6_pkg::*;

   localparam logic MODE_ENC = 1'b0;
   localparam logic MODE_DEC = 1'b1;
   localparam int   IDLE_LIMIT = 20000;
   localparam int   DRAIN_CYCLES = 700;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [31:0] d;
   } block_type;

   typedef struct packed {
      logic      mode;
      block_type blk;
   } cipher_req_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_mode;
   logic [31:0] req_word_a, req_word_b, req_word_c, req_word_d;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_out_a, rsp_out_b, rsp_out_c, rsp_out_d;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [63:0] csr_wdata;

   rc6_block_cipher i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_mode   (req_mode),
      .req_word_a (req_word_a),
      .req_word_b (req_word_b),
      .req_word_c (req_word_c),
      .req_word_d (req_word_d),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_out_a  (rsp_out_a),
      .rsp_out_b  (rsp_out_b),
      .rsp_out_c  (rsp_out_c),
      .rsp_out_d  (rsp_out_d),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // cipher state mirrored in the bench
   logic [6:0]  cfg_rounds;
   logic [8:0]  cfg_key_bits;
   logic [63:0] cfg_key [4];
   logic [31:0] round_keys [StoreDepth];

   cipher_req_type pending_blocks [$];
   block_type      expected_blocks [$];
   bit          burst_mode;
   bit          req_taken;
   bit          rsp_taken;
   int          req_gap;
   int          rsp_wait;
   int          idle_cycles;
   int          mismatches;
   int          n_enc, n_dec, n_settings;

   function automatic logic [31:0] rol32(logic [31:0] x, logic [31:0] n);
      int s;
      s = n & 31;
      if (s == 0) return x;
      return (x << s) | (x >> (32 - s));
   endfunction

   function automatic logic [31:0] ror32(logic [31:0] x, logic [31:0] n);
      int s;
      s = n & 31;
      if (s == 0) return x;
      return (x >> s) | (x << (32 - s));
   endfunction

   function automatic logic [31:0] quad_term(logic [31:0] x);
      logic [31:0] m;
      m = x * ((x << 1) | 32'd1);
      return rol32(m, 5);
   endfunction

   function automatic int active_rounds();
      return (cfg_rounds > MaxRounds) ? MaxRounds : int'(cfg_rounds);
   endfunction

   // rebuild the round keys from the mirrored key registers
   function automatic void expand_round_keys();
      logic [31:0] kw [MaxKeyWords];
      logic [31:0] ka, kb;
      logic [7:0]  kbyte;
      int bits, nwords, nbytes, nkeys, steps, ia, ib;
      bits = (cfg_key_bits > MaxKeyBits) ? MaxKeyBits : int'(cfg_key_bits);
      nwords = (bits + 31) / 32;
      if (nwords == 0) nwords = 1;
      nbytes = bits / 8;
      nkeys = 2 * active_rounds() + 4;
      foreach (kw[k]) kw[k] = '0;
      for (int k = 0; k < nbytes; k++) begin
         kbyte = cfg_key[k >> 3][8 * (k & 7) +: 8];
         kw[k >> 2] |= 32'(kbyte) << (8 * (k & 3));
      end
      round_keys[0] = RC6_P32;
      for (int k = 1; k < nkeys; k++) round_keys[k] = round_keys[k - 1] + RC6_Q32;
      steps = 3 * ((nwords > nkeys) ? nwords : nkeys);
      ka = '0;
      kb = '0;
      ia = 0;
      ib = 0;
      for (int k = 0; k < steps; k++) begin
         ka = rol32(round_keys[ia] + ka + kb, 3);
         round_keys[ia] = ka;
         kb = rol32(kw[ib] + ka + kb, ka + kb);
         kw[ib] = kb;
         ia = (ia + 1) % nkeys;
         ib = (ib + 1) % nwords;
      end
   endfunction

   function automatic block_type cipher_block(cipher_req_type r);
      logic [31:0] a, b, c, d, t, u, tmp;
      int nr;
      nr = active_rounds();
      {a, b, c, d} = r.blk;
      if (r.mode == MODE_ENC) begin
         b += round_keys[0];
         d += round_keys[1];
         for (int i = 1; i <= nr; i++) begin
            t = quad_term(b);
            u = quad_term(d);
            a = rol32(a ^ t, u) + round_keys[2 * i];
            c = rol32(c ^ u, t) + round_keys[2 * i + 1];
            tmp = a; a = b; b = c; c = d; d = tmp;
         end
         a += round_keys[2 * nr + 2];
         c += round_keys[2 * nr + 3];
      end else begin
         c -= round_keys[2 * nr + 3];
         a -= round_keys[2 * nr + 2];
         for (int i = nr; i > 0; i--) begin
            tmp = a; a = d; d = c; c = b; b = tmp;
            u = quad_term(d);
            t = quad_term(b);
            c = ror32(c - round_keys[2 * i + 1], t) ^ u;
            a = ror32(a - round_keys[2 * i], u) ^ t;
         end
         d -= round_keys[1];
         b -= round_keys[0];
      end
      return '{a: a, b: b, c: c, d: d};
   endfunction

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // request driver: hold until taken, then idle a drawn number of cycles
   always @(negedge clock) begin
      if (!reset && !(req_valid && !req_taken)) begin
         if (req_gap > 0) begin
            req_valid <= 1'b0;
            req_gap--;
         end else if (pending_blocks.size() > 0) begin
            cipher_req_type r;
            r = pending_blocks.pop_front();
            req_mode   <= r.mode;
            req_word_a <= r.blk.a;
            req_word_b <= r.blk.b;
            req_word_c <= r.blk.c;
            req_word_d <= r.blk.d;
            req_valid  <= 1'b1;
            req_gap = burst_mode ? 0 : $urandom_range(0, 4);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result stall: draw a new wait after each taken beat
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_taken) rsp_wait = burst_mode ? 0 : $urandom_range(0, 4);
         if (rsp_wait > 0) begin
            rsp_ready <= 1'b0;
            rsp_wait--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // monitor: predict on request beats, check on result beats
   always @(posedge clock) begin
      block_type got, want;
      bit acc_req, acc_rsp;
      acc_req = !reset && req_valid && req_ready;
      acc_rsp = !reset && rsp_valid && rsp_ready;
      req_taken <= acc_req;
      rsp_taken <= acc_rsp;
      if (acc_req) begin
         expected_blocks.push_back(cipher_block('{mode: req_mode,
            blk: '{a: req_word_a, b: req_word_b, c: req_word_c, d: req_word_d}}));
         if (req_mode == MODE_ENC) n_enc++; else n_dec++;
      end
      if (acc_rsp) begin
         got = '{a: rsp_out_a, b: rsp_out_b, c: rsp_out_c, d: rsp_out_d};
         if (expected_blocks.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat %h", got);
         end else begin
            want = expected_blocks.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: a %h/%h b %h/%h c %h/%h d %h/%h (want/got)",
                     want.a, got.a, want.b, got.b, want.c, got.c, want.d, got.d);
            end
         end
      end
      // watchdog on beat-free cycles
      if (reset || acc_req || acc_rsp) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
         $display("FAILURE");
         $finish;
      end
   end

   task automatic csr_write(logic [2:0] idx, logic [63:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_ROUNDS:  cfg_rounds = data[6:0];
         CSR_KEY_LEN: cfg_key_bits = data[8:0];
         CSR_KEY0, CSR_KEY1, CSR_KEY2, CSR_KEY3: cfg_key[idx - CSR_KEY0] = data;
         default: ;
      endcase
      if (idx <= CSR_KEY3) expand_round_keys();
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic queue_block(logic mode, logic [31:0] a, logic [31:0] b,
                              logic [31:0] c, logic [31:0] d);
      pending_blocks.push_back('{mode: mode, blk: '{a: a, b: b, c: c, d: d}});
   endtask

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [63:0] rand_key();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic drain();
      do @(posedge clock);
      while (pending_blocks.size() > 0 || req_valid || expected_blocks.size() > 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_setting(logic [6:0] r, logic [8:0] kbits);
      csr_write(CSR_ROUNDS, 64'(r));
      csr_write(CSR_KEY_LEN, 64'(kbits));
      for (int k = 0; k < 4; k++) csr_write(CSR_KEY0 + 3'(k), rand_key());
      n_settings++;
   endtask

   // stimulus
   initial begin
      logic [6:0] r;
      logic [8:0] kb;
      int n;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_mode   = MODE_ENC;
      req_word_a = '0;
      req_word_b = '0;
      req_word_c = '0;
      req_word_d = '0;
      rsp_ready  = 1'b0;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      req_taken  = 1'b0;
      rsp_taken  = 1'b0;
      req_gap    = 0;
      rsp_wait   = 0;
      burst_mode = 1'b0;
      mismatches = 0;
      n_enc = 0;
      n_dec = 0;
      n_settings = 1;
      cfg_rounds   = 7'd20;
      cfg_key_bits = 9'd128;
      foreach (cfg_key[k]) cfg_key[k] = '0;
      expand_round_keys();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed and random blocks on the reset key
      queue_block(MODE_ENC, '0, '0, '0, '0);
      queue_block(MODE_DEC, '0, '0, '0, '0);
      queue_block(MODE_ENC, '1, '1, '1, '1);
      queue_block(MODE_DEC, '1, '1, '1, '1);
      queue_block(MODE_ENC, 32'h0302_0100, 32'h0706_0504, 32'h0B0A_0908, 32'h0F0E_0D0C);
      queue_block(MODE_DEC, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
      queue_block(MODE_ENC, 32'h8000_0000, 32'h0000_0001, 32'h8000_0000, 32'h0000_0001);
      for (int i = 0; i < 8; i++)
         queue_block(1'($urandom), $urandom, $urandom, $urandom, $urandom);
      drain();

      // out-of-range indexes must leave the key alone
      csr_write(3'd6, rand_key());
      csr_write(3'd7, rand_key());
      queue_block(MODE_ENC, $urandom, $urandom, $urandom, $urandom);
      queue_block(MODE_DEC, $urandom, $urandom, $urandom, $urandom);
      drain();

      // random phases, extremes first
      for (int p = 0; p < 20; p++) begin
         case (p)
            0: begin r = 7'd0;   kb = 9'd0;   end
            1: begin r = 7'd127; kb = 9'd511; end
            2: begin r = 7'd125; kb = 9'd256; end
            3: begin r = 7'd1;   kb = 9'd7;   end
            4: begin r = 7'd20;  kb = 9'd8;   end
            5: begin r = 7'd126; kb = 9'd1;   end
            6: begin r = 7'd2;   kb = 9'd257; end
            default: begin
               r  = 7'($urandom_range(0, 30));
               kb = 9'($urandom_range(0, 511));
            end
         endcase
         apply_setting(r, kb);
         burst_mode = (p % 5 == 3);
         n = (r > 40) ? 20 : 72;
         for (int i = 0; i < n; i++)
            queue_block(1'($urandom), rand_word(), rand_word(), rand_word(), rand_word());
         drain();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("ran %0d encrypt and %0d decrypt blocks across %0d key/round settings",
               n_enc, n_dec, n_settings);
      $display("%0d mismatches, %0d results left unmatched", mismatches,
               expected_blocks.size());
      if (mismatches == 0 && expected_blocks.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
